FILE: rtl/h3fsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3fsp_pkg
// Types, codes and helpers shared by the HTTP/3 frame stream parser.
// ----------------------------------------------------------------------------
package h3fsp_pkg;

  localparam int unsigned VarW = 62;

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_LEN   = 3'd1,
    PH_PASS  = 3'd2,
    PH_SID   = 3'd3,
    PH_SVAL  = 3'd4,
    PH_ONE   = 3'd5,
    PH_EXTRA = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_HDR  = 3'd0,
    EV_BYTE = 3'd1,
    EV_PAIR = 3'd2,
    EV_ONE  = 3'd3,
    EV_ERR  = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    CLS_DATA     = 3'd0,
    CLS_HEADERS  = 3'd1,
    CLS_SETTINGS = 3'd2,
    CLS_GOAWAY   = 3'd3,
    CLS_MAX_PUSH = 3'd4,
    CLS_CANCEL   = 3'd5,
    CLS_OTHER    = 3'd6
  } class_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_SETTINGS = 2'd1,
    ST_BAD_SINGLE   = 2'd2,
    ST_TRUNCATED    = 2'd3
  } status_e;

  localparam logic [VarW-1:0] FT_DATA     = 62'd0;
  localparam logic [VarW-1:0] FT_HEADERS  = 62'd1;
  localparam logic [VarW-1:0] FT_CANCEL   = 62'd3;
  localparam logic [VarW-1:0] FT_SETTINGS = 62'd4;
  localparam logic [VarW-1:0] FT_GOAWAY   = 62'd7;
  localparam logic [VarW-1:0] FT_MAX_PUSH = 62'd13;

  typedef struct packed {
    event_e            ev;
    class_e            cls;
    logic [VarW-1:0]   ftype;
    logic [VarW-1:0]   flen;
    logic [7:0]        body;
    logic [VarW-1:0]   sid;
    logic [VarW-1:0]   nval;
    logic              fend;
    status_e           status;
  } res_t;

  function automatic class_e classify(input logic [VarW-1:0] t);
    class_e c;
    if (t == FT_DATA) c = CLS_DATA;
    else if (t == FT_HEADERS) c = CLS_HEADERS;
    else if (t == FT_SETTINGS) c = CLS_SETTINGS;
    else if (t == FT_GOAWAY) c = CLS_GOAWAY;
    else if (t == FT_MAX_PUSH) c = CLS_MAX_PUSH;
    else if (t == FT_CANCEL) c = CLS_CANCEL;
    else c = CLS_OTHER;
    return c;
  endfunction

  function automatic logic is_single(input class_e c);
    return (c == CLS_GOAWAY) || (c == CLS_MAX_PUSH) || (c == CLS_CANCEL);
  endfunction

endpackage

FILE: rtl/h3_frame_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3_frame_stream_parser
// HTTP/3 frame parser over a byte stream with QUIC varint type and length.
// ----------------------------------------------------------------------------
// flow: each byte is held in the input register, and its result, if any, goes to the result register
// throughput: one byte per cycle while the master side takes results, set by the combinational
// varint and state update between the input register and the result register
// reset: asynchronous, active low; parser waits for a frame type, both stages empty
module h3_frame_stream_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,   // buffer_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // frame_type, frame_length, body_byte, setting_id, number_value
  output logic [255:0] m_axis_tdata_o,
  output logic [7:0]   m_axis_tuser_o,   // event_res, frame_class, status
  output logic         m_axis_tlast_o    // frame_end
);

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_v_q, out_v_d;
  h3fsp_pkg::res_t out_q;
  h3fsp_pkg::res_t res;
  logic       res_valid;
  logic       advance;

  assign advance         = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || advance;

  h3fsp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_v_d = in_v_q;
    if (s_axis_tready_o) in_v_d = s_axis_tvalid_i;
    out_v_d = out_v_q;
    if (advance) out_v_d = res_valid;
    else if (m_axis_tready_i) out_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.nval, out_q.sid, out_q.body, out_q.flen, out_q.ftype};
  assign m_axis_tuser_o  = {out_q.status, out_q.cls, out_q.ev};
  assign m_axis_tlast_o  = out_q.fend;

endmodule

FILE: rtl/h3fsp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3fsp_parser
// Frame parser state and per-byte update: varint decode, header, body handling.
// ----------------------------------------------------------------------------
module h3fsp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic              res_valid_o,
  output h3fsp_pkg::res_t   res_o
);

  localparam int unsigned W = h3fsp_pkg::VarW;

  h3fsp_pkg::phase_e ph_q, ph_d;
  logic [W-1:0]      acc_q, acc_d;
  logic [2:0]        left_q, left_d;
  logic [W-1:0]      type_q, type_d;
  h3fsp_pkg::class_e class_q, class_d;
  logic [W-1:0]      len_q, len_d;
  logic [W-1:0]      body_q, body_d;
  logic [W-1:0]      pid_q, pid_d;

  logic [W-1:0] vs_acc;
  logic [2:0]   vs_left;
  logic         vs_done;
  logic [W-1:0] body_dec;
  logic         body_zero;
  logic         hdr, has, done;

  // varint step: first byte sets the size from its top two bits
  always_comb begin
    if (left_q == 3'd0) begin
      vs_acc  = {{(W-6){1'b0}}, byte_i[5:0]};
      vs_left = 3'((4'd1 << byte_i[7:6]) - 4'd1);
    end else begin
      vs_acc  = {acc_q[W-9:0], byte_i};
      vs_left = left_q - 3'd1;
    end
    vs_done = (vs_left == 3'd0);
  end

  assign body_dec  = body_q - {{(W-1){1'b0}}, 1'b1};
  assign body_zero = (body_dec == '0);

  always_comb begin
    ph_d    = ph_q;
    acc_d   = acc_q;
    left_d  = left_q;
    type_d  = type_q;
    class_d = class_q;
    len_d   = len_q;
    body_d  = body_q;
    pid_d   = pid_q;
    hdr     = (ph_q == h3fsp_pkg::PH_PASS) || (ph_q == h3fsp_pkg::PH_SID) ||
              (ph_q == h3fsp_pkg::PH_SVAL) || (ph_q == h3fsp_pkg::PH_ONE) ||
              (ph_q == h3fsp_pkg::PH_EXTRA);
    has     = 1'b0;
    done    = 1'b0;
    res_o        = '0;
    res_o.ev     = h3fsp_pkg::EV_HDR;
    res_o.status = h3fsp_pkg::ST_OK;

    unique case (ph_q)
      h3fsp_pkg::PH_LEN: begin
        acc_d  = vs_acc;
        left_d = vs_left;
        if (vs_done) begin
          len_d    = vs_acc;
          body_d   = vs_acc;
          class_d  = h3fsp_pkg::classify(type_q);
          acc_d    = '0;
          hdr      = 1'b1;
          has      = 1'b1;
          res_o.ev = h3fsp_pkg::EV_HDR;
          if (vs_acc == '0) begin
            res_o.fend = 1'b1;
            done       = 1'b1;
            if (h3fsp_pkg::is_single(class_d)) res_o.status = h3fsp_pkg::ST_BAD_SINGLE;
          end else if (class_d == h3fsp_pkg::CLS_SETTINGS) begin
            ph_d = h3fsp_pkg::PH_SID;
          end else if (h3fsp_pkg::is_single(class_d)) begin
            ph_d = h3fsp_pkg::PH_ONE;
          end else begin
            ph_d = h3fsp_pkg::PH_PASS;
          end
        end
      end
      h3fsp_pkg::PH_PASS: begin
        body_d     = body_dec;
        has        = 1'b1;
        res_o.ev   = h3fsp_pkg::EV_BYTE;
        res_o.body = byte_i;
        if (body_zero) begin
          res_o.fend = 1'b1;
          done       = 1'b1;
        end
      end
      h3fsp_pkg::PH_SID: begin
        body_d = body_dec;
        acc_d  = vs_acc;
        left_d = vs_left;
        if (vs_done) begin
          pid_d = vs_acc;
          ph_d  = h3fsp_pkg::PH_SVAL;
        end
        if (body_zero) begin
          has          = 1'b1;
          res_o.ev     = h3fsp_pkg::EV_ERR;
          res_o.status = h3fsp_pkg::ST_BAD_SETTINGS;
          res_o.fend   = 1'b1;
          done         = 1'b1;
        end
      end
      h3fsp_pkg::PH_SVAL: begin
        body_d = body_dec;
        acc_d  = vs_acc;
        left_d = vs_left;
        if (vs_done) begin
          has        = 1'b1;
          res_o.ev   = h3fsp_pkg::EV_PAIR;
          res_o.sid  = pid_q;
          res_o.nval = vs_acc;
          ph_d       = h3fsp_pkg::PH_SID;
          if (body_zero) begin
            res_o.fend = 1'b1;
            done       = 1'b1;
          end
        end else if (body_zero) begin
          has          = 1'b1;
          res_o.ev     = h3fsp_pkg::EV_ERR;
          res_o.status = h3fsp_pkg::ST_BAD_SETTINGS;
          res_o.fend   = 1'b1;
          done         = 1'b1;
        end
      end
      h3fsp_pkg::PH_ONE: begin
        body_d = body_dec;
        acc_d  = vs_acc;
        left_d = vs_left;
        if (vs_done && body_zero) begin
          has        = 1'b1;
          res_o.ev   = h3fsp_pkg::EV_ONE;
          res_o.nval = vs_acc;
          res_o.fend = 1'b1;
          done       = 1'b1;
        end else if (vs_done) begin
          ph_d = h3fsp_pkg::PH_EXTRA;
        end else if (body_zero) begin
          has          = 1'b1;
          res_o.ev     = h3fsp_pkg::EV_ERR;
          res_o.status = h3fsp_pkg::ST_BAD_SINGLE;
          res_o.fend   = 1'b1;
          done         = 1'b1;
        end
      end
      h3fsp_pkg::PH_EXTRA: begin
        body_d = body_dec;
        if (body_zero) begin
          has          = 1'b1;
          res_o.ev     = h3fsp_pkg::EV_ERR;
          res_o.status = h3fsp_pkg::ST_BAD_SINGLE;
          res_o.fend   = 1'b1;
          done         = 1'b1;
        end
      end
      default: begin
        // frame type, also recovers from the unused phase code
        ph_d   = h3fsp_pkg::PH_TYPE;
        acc_d  = vs_acc;
        left_d = vs_left;
        if (vs_done) begin
          type_d = vs_acc;
          acc_d  = '0;
          ph_d   = h3fsp_pkg::PH_LEN;
        end
      end
    endcase

    // buffer end mid-frame drops the partial frame
    if (!done && last_i) begin
      if (!has) begin
        has      = 1'b1;
        res_o.ev = h3fsp_pkg::EV_ERR;
      end
      res_o.status = h3fsp_pkg::ST_TRUNCATED;
      res_o.fend   = 1'b1;
    end
    if (done || last_i) begin
      ph_d   = h3fsp_pkg::PH_TYPE;
      acc_d  = '0;
      left_d = 3'd0;
      body_d = '0;
      pid_d  = '0;
    end

    res_o.cls   = hdr ? class_d : h3fsp_pkg::CLS_DATA;
    res_o.ftype = hdr ? type_d : '0;
    res_o.flen  = hdr ? len_d : '0;
    res_valid_o = has;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= h3fsp_pkg::PH_TYPE;
      acc_q   <= '0;
      left_q  <= 3'd0;
      type_q  <= '0;
      class_q <= h3fsp_pkg::CLS_DATA;
      len_q   <= '0;
      body_q  <= '0;
      pid_q   <= '0;
    end else if (en_i) begin
      ph_q    <= ph_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      type_q  <= type_d;
      class_q <= class_d;
      len_q   <= len_d;
      body_q  <= body_d;
      pid_q   <= pid_d;
    end
  end

endmodule

FILE: sim/h3_frame_stream_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3_frame_stream_parser_checker
// Watches both stream channels of the frame parser. Each byte taken on the
// slave side goes through a local copy of the frame parsing state, and the
// events it should cause are queued. Events seen on the master side are
// checked field by field against that queue, oldest first.
// ----------------------------------------------------------------------------
module h3_frame_stream_parser_checker
  import h3fsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,   // buffer_end
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // frame_type, frame_length, body_byte, setting_id, number_value
  input  logic [255:0] m_axis_tdata_i,
  input  logic [7:0]   m_axis_tuser_i,   // event_res, frame_class, status
  input  logic         m_axis_tlast_i,   // frame_end
  output int           fail_count_o,
  output int           pending_o
);

  phase_e          parse_phase;
  logic [VarW-1:0] acc_value;
  logic [2:0]      acc_left;
  logic [VarW-1:0] cur_type;
  class_e          cur_class;
  logic [VarW-1:0] cur_length;
  logic [VarW-1:0] body_remaining;
  logic [VarW-1:0] id_held;

  res_t frame_events_due[$];
  int   mismatches = 0;
  int   waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic class_e class_of(input logic [VarW-1:0] t);
    case (t)
      FT_DATA:     return CLS_DATA;
      FT_HEADERS:  return CLS_HEADERS;
      FT_SETTINGS: return CLS_SETTINGS;
      FT_GOAWAY:   return CLS_GOAWAY;
      FT_MAX_PUSH: return CLS_MAX_PUSH;
      FT_CANCEL:   return CLS_CANCEL;
      default:     return CLS_OTHER;
    endcase
  endfunction

  function automatic logic carries_one_value(input class_e c);
    return (c == CLS_GOAWAY) || (c == CLS_MAX_PUSH) || (c == CLS_CANCEL);
  endfunction

  // shift one byte into the varint, returns 1 once the varint is complete
  function automatic logic varint_take(input logic [7:0] b);
    if (acc_left == 3'd0) begin
      acc_value = {56'd0, b[5:0]};
      acc_left  = 3'((32'd1 << b[7:6]) - 32'd1);
    end else begin
      acc_value = {acc_value[VarW-9:0], b};
      acc_left  = acc_left - 3'd1;
    end
    return acc_left == 3'd0;
  endfunction

  function automatic void restart_parse();
    parse_phase    = PH_TYPE;
    acc_value      = '0;
    acc_left       = '0;
    body_remaining = '0;
    id_held        = '0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic buf_end);
    res_t r;
    logic emit;
    logic done;
    logic hdr;
    logic fin;
    r    = '0;
    emit = 1'b0;
    done = 1'b0;
    hdr  = (parse_phase >= PH_PASS) && (parse_phase <= PH_EXTRA);
    case (parse_phase)
      PH_LEN: begin
        if (varint_take(b)) begin
          cur_length     = acc_value;
          body_remaining = acc_value;
          cur_class      = class_of(cur_type);
          acc_value      = '0;
          hdr            = 1'b1;
          emit           = 1'b1;
          r.ev           = EV_HDR;
          if (cur_length == '0) begin
            r.fend = 1'b1;
            done   = 1'b1;
            if (carries_one_value(cur_class)) r.status = ST_BAD_SINGLE;
          end else if (cur_class == CLS_SETTINGS) begin
            parse_phase = PH_SID;
          end else if (carries_one_value(cur_class)) begin
            parse_phase = PH_ONE;
          end else begin
            parse_phase = PH_PASS;
          end
        end
      end
      PH_PASS: begin
        body_remaining = body_remaining - 1'b1;
        emit   = 1'b1;
        r.ev   = EV_BYTE;
        r.body = b;
        if (body_remaining == '0) begin
          r.fend = 1'b1;
          done   = 1'b1;
        end
      end
      PH_SID: begin
        body_remaining = body_remaining - 1'b1;
        if (varint_take(b)) begin
          id_held     = acc_value;
          parse_phase = PH_SVAL;
        end
        // body cannot end inside or right after an id
        if (body_remaining == '0) begin
          emit     = 1'b1;
          r.ev     = EV_ERR;
          r.status = ST_BAD_SETTINGS;
          r.fend   = 1'b1;
          done     = 1'b1;
        end
      end
      PH_SVAL: begin
        body_remaining = body_remaining - 1'b1;
        if (varint_take(b)) begin
          emit        = 1'b1;
          r.ev        = EV_PAIR;
          r.sid       = id_held;
          r.nval      = acc_value;
          parse_phase = PH_SID;
          if (body_remaining == '0) begin
            r.fend = 1'b1;
            done   = 1'b1;
          end
        end else if (body_remaining == '0) begin
          emit     = 1'b1;
          r.ev     = EV_ERR;
          r.status = ST_BAD_SETTINGS;
          r.fend   = 1'b1;
          done     = 1'b1;
        end
      end
      PH_ONE: begin
        body_remaining = body_remaining - 1'b1;
        fin = varint_take(b);
        if (fin && body_remaining == '0) begin
          emit   = 1'b1;
          r.ev   = EV_ONE;
          r.nval = acc_value;
          r.fend = 1'b1;
          done   = 1'b1;
        end else if (fin) begin
          parse_phase = PH_EXTRA;
        end else if (body_remaining == '0) begin
          emit     = 1'b1;
          r.ev     = EV_ERR;
          r.status = ST_BAD_SINGLE;
          r.fend   = 1'b1;
          done     = 1'b1;
        end
      end
      PH_EXTRA: begin
        // trailing bytes after the value are swallowed until the body ends
        body_remaining = body_remaining - 1'b1;
        if (body_remaining == '0) begin
          emit     = 1'b1;
          r.ev     = EV_ERR;
          r.status = ST_BAD_SINGLE;
          r.fend   = 1'b1;
          done     = 1'b1;
        end
      end
      default: begin
        parse_phase = PH_TYPE;
        if (varint_take(b)) begin
          cur_type    = acc_value;
          acc_value   = '0;
          parse_phase = PH_LEN;
        end
      end
    endcase

    if (done) begin
      restart_parse();
    end else if (buf_end) begin
      // partial frame is dropped, the result of this byte (if any) is marked
      if (!emit) begin
        emit = 1'b1;
        r.ev = EV_ERR;
      end
      r.status = ST_TRUNCATED;
      r.fend   = 1'b1;
      restart_parse();
    end

    if (emit) begin
      if (hdr) begin
        r.cls   = cur_class;
        r.ftype = cur_type;
        r.flen  = cur_length;
      end
      frame_events_due.push_back(r);
    end
  endtask

  function automatic void compare_field(input string name, input logic [VarW-1:0] want,
                                        input logic [VarW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_event();
    res_t want;
    res_t got;
    got        = '0;
    got.ev     = event_e'(m_axis_tuser_i[2:0]);
    got.cls    = class_e'(m_axis_tuser_i[5:3]);
    got.status = status_e'(m_axis_tuser_i[7:6]);
    got.ftype  = m_axis_tdata_i[61:0];
    got.flen   = m_axis_tdata_i[123:62];
    got.body   = m_axis_tdata_i[131:124];
    got.sid    = m_axis_tdata_i[193:132];
    got.nval   = m_axis_tdata_i[255:194];
    got.fend   = m_axis_tlast_i;
    if (frame_events_due.size() == 0) begin
      $display("%0t: no event expected, got event 0x%0h status 0x%0h",
               $time, m_axis_tuser_i[2:0], m_axis_tuser_i[7:6]);
      mismatches++;
    end else begin
      want = frame_events_due.pop_front();
      compare_field("event_res",    want.ev,     got.ev);
      compare_field("frame_class",  want.cls,    got.cls);
      compare_field("frame_type",   want.ftype,  got.ftype);
      compare_field("frame_length", want.flen,   got.flen);
      compare_field("body_byte",    want.body,   got.body);
      compare_field("setting_id",   want.sid,    got.sid);
      compare_field("number_value", want.nval,   got.nval);
      compare_field("frame_end",    want.fend,   got.fend);
      compare_field("status",       want.status, got.status);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parse();
      cur_type   = '0;
      cur_class  = CLS_DATA;
      cur_length = '0;
      frame_events_due.delete();
      waiting = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) parse_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_event();
      waiting = frame_events_due.size();
    end
  end

endmodule

FILE: sim/h3_frame_stream_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3_frame_stream_parser_test
// Feeds the frame parser a byte stream: a few hand-made frames covering each
// named frame class and error path, then random frames (mostly well formed, some
// cut short by a buffer end, some with broken lengths, some plain noise).
// Both sides idle at random; the receiver also holds off once for a long
// stretch. The checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module h3_frame_stream_parser_test;
  import h3fsp_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;    // data_byte
  logic         s_axis_tlast;    // buffer_end
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // frame_type, frame_length, body_byte, setting_id, number_value
  logic [255:0] m_axis_tdata;
  logic [7:0]   m_axis_tuser;    // event_res, frame_class, status
  logic         m_axis_tlast;    // frame_end

  int fail_count;
  int pending_count;

  // {buffer_end, byte} for every byte to be sent
  logic [8:0] stream_q[$];
  logic [7:0] frame_q[$];
  logic [7:0] body_q[$];

  h3_frame_stream_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  h3_frame_stream_parser_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VarW-1:0] rand62();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[VarW-1:0];
  endfunction

  function automatic logic [VarW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rand62();
    endcase
  endfunction

  // varint size selector, short forms more often
  function automatic int rand_sel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 7) return 1;
    if (r < 9) return 2;
    return 3;
  endfunction

  // big-endian varint, value bits beyond the chosen size are dropped
  function automatic void push_varint(input logic [VarW-1:0] v, input int sel,
                                      input bit to_body);
    logic [63:0] vv;
    logic [7:0]  b;
    int          n;
    vv = {2'b00, v};
    n  = 1 << sel;
    for (int i = n - 1; i >= 0; i--) begin
      b = vv[8*i +: 8];
      if (i == n - 1) b[7:6] = 2'(sel);
      if (to_body) body_q.push_back(b);
      else frame_q.push_back(b);
    end
  endfunction

  // header from type and body size, then optionally closed or cut short by a buffer end
  function automatic void add_frame(input logic [VarW-1:0] ftype, input int tsel,
                                    input bit allow_cut);
    int   cut;
    logic mark;
    push_varint(ftype, tsel, 1'b0);
    push_varint(VarW'(body_q.size()), rand_sel(), 1'b0);
    foreach (body_q[i]) frame_q.push_back(body_q[i]);
    cut  = frame_q.size() - 1;
    mark = allow_cut && ($urandom_range(0, 7) == 0);
    if (allow_cut && $urandom_range(0, 10) == 0) begin
      cut  = $urandom_range(0, frame_q.size() - 1);
      mark = 1'b1;
    end
    for (int i = 0; i <= cut; i++) stream_q.push_back({mark && (i == cut), frame_q[i]});
    frame_q.delete();
    body_q.delete();
  endfunction

  function automatic void build_directed();
    // data frame carrying one all-ones byte
    body_q.push_back(8'hFF);
    add_frame(FT_DATA, 0, 1'b0);
    // empty headers and empty goaway
    add_frame(FT_HEADERS, 0, 1'b0);
    add_frame(FT_GOAWAY, 0, 1'b0);
    // one settings pair with a zero value
    push_varint(62'd6, 0, 1'b1);
    push_varint(62'd0, 0, 1'b1);
    add_frame(FT_SETTINGS, 0, 1'b0);
    // largest one-byte value
    push_varint('1, 0, 1'b1);
    add_frame(FT_MAX_PUSH, 0, 1'b0);
    // value followed by a stray byte inside the body
    push_varint(62'd5, 0, 1'b1);
    body_q.push_back(8'hAA);
    add_frame(FT_CANCEL, 0, 1'b0);
    // settings body stops after the first byte of a two-byte id
    body_q.push_back(8'h40);
    add_frame(FT_SETTINGS, 0, 1'b0);
    // goaway body stops after the first byte of a four-byte value
    body_q.push_back(8'h80);
    add_frame(FT_GOAWAY, 0, 1'b0);
    // buffer end straight after a frame type byte
    stream_q.push_back({1'b1, 8'h21});
  endfunction

  function automatic void build_random_frame();
    int               kind;
    int               n;
    logic [VarW-1:0]  ftype;
    logic [VarW-1:0]  flen;
    kind = $urandom_range(0, 19);
    if (kind < 7) begin
      case ($urandom_range(0, 2))
        0:       ftype = FT_DATA;
        1:       ftype = FT_HEADERS;
        default: ftype = rand_value();
      endcase
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
      repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
      add_frame(ftype, rand_sel(), 1'b1);
    end else if (kind < 11) begin
      repeat ($urandom_range(0, 3)) begin
        push_varint(rand_value(), rand_sel(), 1'b1);
        push_varint(rand_value(), rand_sel(), 1'b1);
      end
      // sometimes end the body inside an id or a value
      if (body_q.size() > 0 && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(0, body_q.size() - 1);
        while (body_q.size() > n) void'(body_q.pop_back());
      end
      add_frame(FT_SETTINGS, rand_sel(), 1'b1);
    end else if (kind < 16) begin
      case ($urandom_range(0, 2))
        0:       ftype = FT_GOAWAY;
        1:       ftype = FT_MAX_PUSH;
        default: ftype = FT_CANCEL;
      endcase
      push_varint(rand_value(), rand_sel(), 1'b1);
      case ($urandom_range(0, 5))
        0: repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(0, 255)));
        1: begin
          n = $urandom_range(0, body_q.size() - 1);
          while (body_q.size() > n) void'(body_q.pop_back());
        end
        default: ;
      endcase
      add_frame(ftype, rand_sel(), 1'b1);
    end else if (kind < 18) begin
      // noise, closed by a buffer end so parsing starts clean afterwards
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) stream_q.push_back({i == n - 1, 8'($urandom_range(0, 255))});
    end else begin
      // huge length, always cut short by a buffer end
      case ($urandom_range(0, 3))
        0:       ftype = FT_DATA;
        1:       ftype = FT_SETTINGS;
        2:       ftype = FT_GOAWAY;
        default: ftype = rand_value();
      endcase
      flen = ($urandom_range(0, 1) == 0) ? '1 : (rand62() | {1'b1, 61'd0});
      push_varint(ftype, rand_sel(), 1'b0);
      push_varint(flen, 3, 1'b0);
      repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      foreach (frame_q[i]) stream_q.push_back({i == frame_q.size() - 1, frame_q[i]});
      frame_q.delete();
    end
  endfunction

  initial begin : stimulus
    bit steady;
    int gap;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    steady        = 1'b0;
    build_directed();
    while (stream_q.size() < 750) build_random_frame();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (stream_q[i]) begin
      if ($urandom_range(0, 49) == 0) steady = !steady;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= stream_q[i][7:0];
      s_axis_tlast  <= stream_q[i][8];
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    wait (pending_count == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("h3_frame_stream_parser_test OK");
    end else begin
      $display("h3_frame_stream_parser_test NOT OK");
    end
    $finish;
  end

  initial begin : receiver
    int  cyc;
    int  hold_left;
    int  run_left;
    bit  ready_on;
    m_axis_tready = 1'b0;
    cyc       = 0;
    hold_left = 0;
    run_left  = 0;
    ready_on  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      // one long hold-off so the parser backs up into its input
      if (cyc == 600) hold_left = 250;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        while (run_left == 0) begin
          ready_on = !ready_on;
          run_left = ready_on ? $urandom_range(1, 40) : pick_gap();
        end
        run_left--;
        m_axis_tready <= ready_on;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("h3_frame_stream_parser_test NOT OK");
    $finish;
  end

endmodule
